// ===== rtl/core/mte_pkg.sv =====
// Shared types and constants of the modem telnet escape datapath.
package mte_pkg;

  localparam logic [7:0] IAC_BYTE  = 8'hFF;
  localparam logic [7:0] PLUS_BYTE = 8'h2B;
  localparam logic [7:0] TN_WILL   = 8'd251;
  localparam logic [7:0] TN_WONT   = 8'd252;
  localparam logic [7:0] TN_DO     = 8'd253;

  localparam logic [15:0] GUARD_RESET = 16'd1000;
  localparam logic [15:0] SINCE_MAX   = 16'hFFFF;
  localparam logic [1:0]  PLUS_FULL   = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  localparam logic REG_TELNET = 1'b0;
  localparam logic REG_GUARD  = 1'b1;

  typedef enum logic [1:0] {
    REQ_TERM = 2'd0,
    REQ_NET  = 2'd1,
    REQ_TICK = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    DEST_NET   = 2'd0,
    DEST_TERM  = 2'd1,
    DEST_EVENT = 2'd2
  } dest_t;

  typedef enum logic [2:0] {
    RX_IDLE = 3'b001,
    RX_IAC  = 3'b010,
    RX_CMD  = 3'b100
  } rx_state_t;

  typedef struct packed {
    dest_t      dest;
    logic [1:0] count;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic       cmd;
  } action_t;

endpackage

// ===== rtl/core/mte_front.sv =====
// Front end: accepts items, keeps plus and telnet receive state, builds actions.
module mte_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 telnet_enable,
  input  logic [15:0]          guard_ticks,
  input  logic                 accept,
  input  logic [1:0]           req_type,
  input  logic [7:0]           data_byte,
  output logic                 push,
  output mte_pkg::action_t     act
);

  logic [1:0]         plus_run;
  logic [1:0]         plus_run_next;
  logic [15:0]        since_plus;
  logic [15:0]        since_plus_next;
  mte_pkg::rx_state_t rx_phase;
  mte_pkg::rx_state_t rx_phase_next;
  logic [7:0]         rx_command;
  logic [7:0]         rx_command_next;
  logic               push_req;

  always_comb begin
    plus_run_next   = plus_run;
    since_plus_next = since_plus;
    rx_phase_next   = rx_phase;
    rx_command_next = rx_command;
    push_req        = 1'b0;
    act             = '0;
    act.dest        = mte_pkg::DEST_NET;
    unique case (req_type)
      mte_pkg::REQ_TERM: begin
        if (data_byte == mte_pkg::PLUS_BYTE) begin
          if (plus_run != mte_pkg::PLUS_FULL) begin
            plus_run_next = plus_run + 2'd1;
          end
          if (plus_run_next == mte_pkg::PLUS_FULL) begin
            since_plus_next = '0;
          end
        end else begin
          plus_run_next = '0;
        end
        push_req  = 1'b1;
        act.dest  = mte_pkg::DEST_NET;
        act.byte0 = data_byte;
        act.byte1 = data_byte;
        act.count = (telnet_enable && data_byte == mte_pkg::IAC_BYTE) ? 2'd2 : 2'd1;
      end
      mte_pkg::REQ_NET: begin
        act.count = 2'd1;
        if (!telnet_enable) begin
          rx_phase_next = mte_pkg::RX_IDLE;
          push_req      = 1'b1;
          act.dest      = mte_pkg::DEST_TERM;
          act.byte0     = data_byte;
        end else begin
          unique case (rx_phase)
            mte_pkg::RX_IAC: begin
              if (data_byte == mte_pkg::IAC_BYTE) begin
                rx_phase_next = mte_pkg::RX_IDLE;
                push_req      = 1'b1;
                act.dest      = mte_pkg::DEST_TERM;
                act.byte0     = mte_pkg::IAC_BYTE;
              end else begin
                rx_command_next = data_byte;
                rx_phase_next   = mte_pkg::RX_CMD;
              end
            end
            mte_pkg::RX_CMD: begin
              rx_phase_next = mte_pkg::RX_IDLE;
              act.dest      = mte_pkg::DEST_NET;
              act.count     = 2'd3;
              act.byte0     = mte_pkg::IAC_BYTE;
              act.byte2     = data_byte;
              if (rx_command == mte_pkg::TN_DO) begin
                push_req  = 1'b1;
                act.byte1 = mte_pkg::TN_WONT;
              end else if (rx_command == mte_pkg::TN_WILL) begin
                push_req  = 1'b1;
                act.byte1 = mte_pkg::TN_DO;
              end
            end
            default: begin
              if (data_byte == mte_pkg::IAC_BYTE) begin
                rx_phase_next = mte_pkg::RX_IAC;
              end else begin
                rx_phase_next = mte_pkg::RX_IDLE;
                push_req      = 1'b1;
                act.dest      = mte_pkg::DEST_TERM;
                act.byte0     = data_byte;
              end
            end
          endcase
        end
      end
      mte_pkg::REQ_TICK: begin
        if (since_plus != mte_pkg::SINCE_MAX) begin
          since_plus_next = since_plus + 16'd1;
        end
        if (plus_run == mte_pkg::PLUS_FULL && since_plus_next > guard_ticks) begin
          plus_run_next = '0;
          push_req      = 1'b1;
          act.dest      = mte_pkg::DEST_EVENT;
          act.count     = 2'd1;
          act.cmd       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign push = accept && push_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      plus_run   <= '0;
      since_plus <= '0;
      rx_phase   <= mte_pkg::RX_IDLE;
      rx_command <= '0;
    end else if (accept) begin
      plus_run   <= plus_run_next;
      since_plus <= since_plus_next;
      rx_phase   <= rx_phase_next;
      rx_command <= rx_command_next;
    end
  end

  a_event_clears_plus: assert property (@(posedge clk) disable iff (rst)
    push && act.cmd |=> plus_run == 2'd0)
    else $error("plus run not cleared after command event");

  a_reply_needs_cmd_phase: assert property (@(posedge clk) disable iff (rst)
    push && act.count == 2'd3 |-> rx_phase == mte_pkg::RX_CMD)
    else $error("negotiation reply outside command phase");

endmodule

// ===== rtl/core/mte_queue.sv =====
// Small action queue between the front end and the back end.
module mte_queue #(
  parameter int DEPTH = mte_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mte_pkg::action_t push_data,
  output logic             full,
  input  logic             pop,
  output mte_pkg::action_t pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  mte_pkg::action_t slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

// ===== rtl/core/mte_back.sv =====
// Back end: expands queued actions into result items through an output register.
module mte_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  mte_pkg::action_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       dest,
  output logic [7:0]       out_byte,
  output logic             enter_command,
  output logic             last
);

  mte_pkg::action_t cur;
  logic             cur_valid;
  logic [1:0]       idx;
  logic             advance;
  logic             emit;
  logic             at_end;
  logic             fin;
  logic [7:0]       sel_byte;

  assign advance = !out_valid || !out_stall;
  assign emit    = cur_valid && advance;
  assign at_end  = (idx == cur.count - 2'd1);
  assign fin     = emit && at_end;
  assign q_pop   = !q_empty && (!cur_valid || fin);

  always_comb begin
    unique case (idx)
      2'd0:    sel_byte = cur.byte0;
      2'd1:    sel_byte = cur.byte1;
      default: sel_byte = cur.byte2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (fin) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        idx <= idx + 2'd1;
      end
      if (advance) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (emit) begin
      dest          <= cur.dest;
      out_byte      <= sel_byte;
      enter_command <= cur.cmd;
      last          <= at_end;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> cur.count != 2'd0 && idx < cur.count)
    else $error("result index beyond action count");

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> cur_valid && idx == 2'd0)
    else $error("popped action not loaded");

endmodule

// ===== rtl/core/modem_telnet_escape_datapath.sv =====
// Top level of the modem telnet escape datapath: register port, front, queue, back.
// An item's results pass the action queue, the current action and the output register.
// Throughput: one result per cycle when out_stall is low; zero to three results per item.
// Input is taken every cycle while the two-entry action queue has room.
// Reset (rst, synchronous): telnet off, guard 1000, all counters and phases cleared,
// queue and output register empty.
module modem_telnet_escape_datapath #(
  parameter int QUEUE_DEPTH = mte_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  dest,
  output logic [7:0]  out_byte,
  output logic        enter_command,
  output logic        last
);

  logic             telnet_enable;
  logic [15:0]      guard_ticks;
  logic             cfg_write;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  logic             accept;
  mte_pkg::action_t front_act;
  mte_pkg::action_t q_data;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == mte_pkg::REG_GUARD) ? {16'd0, guard_ticks}
                                                      : {31'd0, telnet_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      telnet_enable <= 1'b0;
      guard_ticks   <= mte_pkg::GUARD_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == mte_pkg::REG_TELNET) begin
        telnet_enable <= pwdata[0];
      end else begin
        guard_ticks <= pwdata[15:0];
      end
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  mte_front u_front (
    .clk           (clk),
    .rst           (rst),
    .telnet_enable (telnet_enable),
    .guard_ticks   (guard_ticks),
    .accept        (accept),
    .req_type      (req_type),
    .data_byte     (data_byte),
    .push          (q_push),
    .act           (front_act)
  );

  mte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_act),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  mte_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .dest          (dest),
    .out_byte      (out_byte),
    .enter_command (enter_command),
    .last          (last)
  );

endmodule

// ===== tb/tb_top.sv =====
// Testbench of the modem telnet escape datapath: scoreboard, item drivers and result checks.
module tb_top;

  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          PHASE_ITEMS    = 60;
  localparam logic [1:0]  REQ_UNUSED     = 2'd3;
  localparam logic [7:0]  SB_OPTION      = 8'd250;

  typedef struct packed {
    mte_pkg::dest_t dest;
    logic [7:0]     data;
    logic           cmd;
    logic           last;
  } result_t;

  class escape_scoreboard;
    bit                 telnet_on;
    logic [15:0]        guard;
    logic [1:0]         plus_run;
    logic [15:0]        since_plus;
    mte_pkg::rx_state_t rx_state;
    logic [7:0]         rx_cmd;
    result_t            due_results[$];
    int                 errors;

    function new();
      telnet_on  = 1'b0;
      guard      = mte_pkg::GUARD_RESET;
      plus_run   = '0;
      since_plus = '0;
      rx_state   = mte_pkg::RX_IDLE;
      rx_cmd     = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == mte_pkg::REG_TELNET) begin
        telnet_on = val[0];
      end else begin
        guard = val[15:0];
      end
    endfunction

    function void push(mte_pkg::dest_t d, logic [7:0] b, logic c, logic l);
      result_t r;
      r.dest = d;
      r.data = b;
      r.cmd  = c;
      r.last = l;
      due_results.push_back(r);
    endfunction

    function void take_item(logic [1:0] rt, logic [7:0] b);
      case (rt)
        mte_pkg::REQ_TERM: begin
          if (b == mte_pkg::PLUS_BYTE) begin
            if (plus_run != mte_pkg::PLUS_FULL) plus_run = plus_run + 2'd1;
            if (plus_run == mte_pkg::PLUS_FULL) since_plus = '0;
          end else begin
            plus_run = '0;
          end
          if (telnet_on && b == mte_pkg::IAC_BYTE) push(mte_pkg::DEST_NET, b, 1'b0, 1'b0);
          push(mte_pkg::DEST_NET, b, 1'b0, 1'b1);
        end
        mte_pkg::REQ_NET: begin
          if (!telnet_on) begin
            rx_state = mte_pkg::RX_IDLE;
            push(mte_pkg::DEST_TERM, b, 1'b0, 1'b1);
          end else if (rx_state == mte_pkg::RX_IAC) begin
            if (b == mte_pkg::IAC_BYTE) begin
              rx_state = mte_pkg::RX_IDLE;
              push(mte_pkg::DEST_TERM, mte_pkg::IAC_BYTE, 1'b0, 1'b1);
            end else begin
              rx_cmd   = b;
              rx_state = mte_pkg::RX_CMD;
            end
          end else if (rx_state == mte_pkg::RX_CMD) begin
            rx_state = mte_pkg::RX_IDLE;
            if (rx_cmd == mte_pkg::TN_DO || rx_cmd == mte_pkg::TN_WILL) begin
              push(mte_pkg::DEST_NET, mte_pkg::IAC_BYTE, 1'b0, 1'b0);
              push(mte_pkg::DEST_NET,
                   (rx_cmd == mte_pkg::TN_DO) ? mte_pkg::TN_WONT : mte_pkg::TN_DO,
                   1'b0, 1'b0);
              push(mte_pkg::DEST_NET, b, 1'b0, 1'b1);
            end
          end else if (b == mte_pkg::IAC_BYTE) begin
            rx_state = mte_pkg::RX_IAC;
          end else begin
            push(mte_pkg::DEST_TERM, b, 1'b0, 1'b1);
          end
        end
        mte_pkg::REQ_TICK: begin
          if (since_plus != mte_pkg::SINCE_MAX) since_plus = since_plus + 16'd1;
          if (plus_run == mte_pkg::PLUS_FULL && since_plus > guard) begin
            plus_run = '0;
            push(mte_pkg::DEST_EVENT, 8'h00, 1'b1, 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(logic [1:0] d, logic [7:0] b, logic c, logic l);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing due: dest %0h byte %0h cmd %0b last %0b",
                 $time, d, b, c, l);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (d !== want.dest) report("dest", want.dest, d);
      if (b !== want.data) report("out_byte", want.data, b);
      if (c !== want.cmd) report("enter_command", want.cmd, c);
      if (l !== want.last) report("last", want.last, l);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  dest;
  logic [7:0]  out_byte;
  logic        enter_command;
  logic        last;

  int               send_idle_pct = 0;
  int               stall_pct = 0;
  int               idle_cycles = 0;
  escape_scoreboard sb;

  modem_telnet_escape_datapath i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .dest          (dest),
    .out_byte      (out_byte),
    .enter_command (enter_command),
    .last          (last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(dest, out_byte, enter_command, last);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("modem_telnet_escape_datapath test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_item(input logic [1:0] rt, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= rt;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.take_item(rt, b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_plus_run(input int n);
    repeat (n) send_item(mte_pkg::REQ_TERM, mte_pkg::PLUS_BYTE);
  endtask

  task automatic random_phase(input int n_items);
    int         sent;
    int         kind;
    int         pick;
    int         reps;
    int         span;
    logic [7:0] cmd;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        pick = $urandom_range(4);
        case (pick)
          0: cmd = mte_pkg::TN_DO;
          1: cmd = mte_pkg::TN_WILL;
          2: cmd = mte_pkg::IAC_BYTE;
          3: cmd = mte_pkg::TN_WONT;
          default: cmd = 8'($urandom_range(255));
        endcase
        send_item(mte_pkg::REQ_NET, mte_pkg::IAC_BYTE);
        send_item(mte_pkg::REQ_NET, cmd);
        sent += 2;
        if (cmd != mte_pkg::IAC_BYTE) begin
          send_item(mte_pkg::REQ_NET, 8'($urandom_range(255)));
          sent++;
        end
      end else if (kind < 45) begin
        reps = $urandom_range(2, 5);
        send_plus_run(reps);
        sent += reps;
        span = (sb.guard > 9) ? 12 : int'(sb.guard) + 3;
        reps = $urandom_range(span);
        repeat (reps) send_item(mte_pkg::REQ_TICK, 8'($urandom_range(255)));
        sent += reps;
      end else if (kind < 55) begin
        reps = $urandom_range(1, 3);
        repeat (reps) send_item(mte_pkg::REQ_TICK, 8'($urandom_range(255)));
        sent += reps;
      end else if (kind < 95) begin
        send_item($urandom_range(1) ? mte_pkg::REQ_NET : mte_pkg::REQ_TERM,
                  ($urandom_range(9) == 0) ? mte_pkg::IAC_BYTE : 8'($urandom_range(255)));
        sent++;
      end else begin
        send_item(REQ_UNUSED, 8'($urandom_range(255)));
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: telnet off, guard at its reset value
    send_item(mte_pkg::REQ_TERM, 8'h00);
    send_item(mte_pkg::REQ_TERM, mte_pkg::IAC_BYTE);
    send_item(mte_pkg::REQ_NET, mte_pkg::IAC_BYTE);
    send_item(mte_pkg::REQ_NET, 8'h00);
    send_item(REQ_UNUSED, 8'hAA);
    send_item(mte_pkg::REQ_TICK, 8'h55);
    drain();

    reg_write(mte_pkg::REG_TELNET, 32'd1);
    reg_write(mte_pkg::REG_GUARD, 32'd0);
    send_item(mte_pkg::REQ_TERM, mte_pkg::IAC_BYTE);
    send_item(mte_pkg::REQ_NET, mte_pkg::IAC_BYTE);
    send_item(mte_pkg::REQ_NET, mte_pkg::IAC_BYTE);
    send_item(mte_pkg::REQ_NET, mte_pkg::IAC_BYTE);
    send_item(mte_pkg::REQ_NET, mte_pkg::TN_DO);
    send_item(mte_pkg::REQ_NET, 8'h01);
    send_item(mte_pkg::REQ_NET, mte_pkg::IAC_BYTE);
    send_item(mte_pkg::REQ_NET, mte_pkg::TN_WILL);
    send_item(mte_pkg::REQ_NET, 8'h18);
    send_item(mte_pkg::REQ_NET, mte_pkg::IAC_BYTE);
    send_item(mte_pkg::REQ_NET, SB_OPTION);
    send_item(mte_pkg::REQ_NET, 8'h55);
    send_plus_run(4);
    send_item(mte_pkg::REQ_TICK, 8'h00);
    send_item(mte_pkg::REQ_TICK, 8'hFF);
    // Abandon a half-received IAC sequence by turning telnet off
    send_item(mte_pkg::REQ_NET, mte_pkg::IAC_BYTE);
    drain();
    reg_write(mte_pkg::REG_TELNET, 32'd0);
    send_item(mte_pkg::REQ_NET, 8'h41);
    drain();
    reg_write(mte_pkg::REG_TELNET, 32'd1);
    send_item(mte_pkg::REQ_NET, mte_pkg::TN_WILL);
    drain();

    reg_write(mte_pkg::REG_GUARD, 32'd2);
    random_phase(PHASE_ITEMS);

    send_idle_pct = 66;
    reg_write(mte_pkg::REG_TELNET, 32'd0);
    reg_write(mte_pkg::REG_GUARD, 32'd1);
    random_phase(PHASE_ITEMS);

    send_idle_pct = 0;
    stall_pct = 66;
    reg_write(mte_pkg::REG_TELNET, 32'd1);
    reg_write(mte_pkg::REG_GUARD, 32'd0);
    random_phase(PHASE_ITEMS);

    send_idle_pct = 18;
    stall_pct = 18;
    reg_write(mte_pkg::REG_GUARD, 32'd4);
    random_phase(PHASE_ITEMS);

    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("modem_telnet_escape_datapath test passed");
    end else begin
      $display("modem_telnet_escape_datapath test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mte_pkg.sv
rtl/core/mte_front.sv
rtl/core/mte_queue.sv
rtl/core/mte_back.sv
rtl/core/modem_telnet_escape_datapath.sv
tb/tb_top.sv
